FILE: rtl/core/ssl_pkg.sv
// Shared types and codes for the signal-sorted satellite list.
// Used by ssl_cell and signal_sorted_satellite_list_top; no dependencies.
package ssl_pkg;

  // One stored satellite record, the sort key in the top bits
  typedef struct packed {
    logic [7:0]        signal;
    logic              in_use;
    logic signed [7:0] elevation;
    logic [8:0]        azimuth;
    logic [7:0]        sat_id;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Per-cell control, driven by the top level
  typedef struct packed {
    logic ins;     // an insert is being applied this cycle
    logic valid;   // cell holds a record (index below count)
    logic at_end;  // cell is the first free slot (index equals count)
  } cell_ctl_t;

  // Request kinds
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_WEAK     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

FILE: rtl/core/ssl_cell.sv
// One slot of the sorted record chain: holds a record, compares its key.
// Depends on ssl_pkg for rec_t and cell_ctl_t.
module ssl_cell (
  input  logic              clk,
  input  ssl_pkg::cell_ctl_t ctl,
  input  logic              prev_gt,   // left neighbor holds a stronger record
  input  ssl_pkg::rec_t     prev_rec,  // left neighbor's record
  input  ssl_pkg::rec_t     new_rec,   // record being inserted
  output logic              gt,        // this cell holds a stronger record
  output ssl_pkg::rec_t     rec        // record held here
);
  import ssl_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;

  // strictly greater keeps equal-strength records ahead of the new one
  assign gt  = ctl.valid && (rec_r.signal > new_rec.signal);
  assign rec = rec_r;

  // shift right past the insert point, take the new record at it
  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins) begin
      if (prev_gt) begin
        rec_nxt = prev_rec;
      end else if (gt || ctl.at_end) begin
        rec_nxt = new_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

FILE: rtl/core/signal_sorted_satellite_list_top.sv
// Signal-sorted satellite list, top level.
// Depends on ssl_pkg and ssl_cell.
//
// Usage:
//   Requests enter on the in_ stream: in_tuser is the request kind (clear,
//   insert, read), in_tdata the record and the read index. Each request gives
//   exactly one item on the out_ stream: out_tuser is the status, out_tdata
//   the count after the request and, for a good read, the record read.
//   Records are kept in a chain of MAX_RECORDS cells, weakest first; on an
//   insert every cell compares its key with the new one and the cells past
//   the insert point shift one place right in the same cycle.
//   Result: registered, shown in the cycle after the request is accepted.
//   Throughput: one request per cycle while out_tready is high, set by the
//   compare and shift across the cell chain; the output register holds one result.
//   Stall: while a result waits with out_tready low, in_tready is low.
//   Reset (rst_n low, synchronous): count to zero, output empty, min_signal
//   to zero. Cell contents are not cleared; only cells below the count are
//   ever read.
//   cfg_we with cfg_wdata sets min_signal; write it only while idle.
module signal_sorted_satellite_list_top #(
  parameter int MAX_RECORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,    // min_signal
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,     // [1:0] req_type
  input  logic [39:0] in_tdata,     // [7:0] sat_id, [16:8] azimuth_deg,
                                    // [24:17] elevation_deg, [25] in_use,
                                    // [33:26] signal_strength,
                                    // [38:34] read_index, [39] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,    // [1:0] status
  output logic [39:0] out_tdata     // [5:0] entry_count, [13:6] out_sat_id,
                                    // [22:14] out_azimuth_deg,
                                    // [30:23] out_elevation_deg,
                                    // [31] out_in_use, [39:32] out_signal
);
  import ssl_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  // registers
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       min_signal_r;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_user_r, out_user_nxt;
  logic [39:0]      out_data_r, out_data_nxt;

  // request decode
  logic        accept;
  logic [1:0]  req;
  rec_t        new_rec;
  logic [4:0]  read_index;
  logic        is_weak, is_full, ins_ok, not_found;

  // chain wiring
  cell_ctl_t   ctl    [MAX_RECORDS];
  logic        gt     [MAX_RECORDS];
  rec_t        rec    [MAX_RECORDS];
  logic        rd_sel [MAX_RECORDS];
  logic [REC_W-1:0] rd_bits;
  rec_t        rd_rec;
  logic [CNT_W+5:0] count_ext;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign req                = in_tuser;
  assign new_rec.sat_id     = in_tdata[7:0];
  assign new_rec.azimuth    = in_tdata[16:8];
  assign new_rec.elevation  = in_tdata[24:17];
  assign new_rec.in_use     = in_tdata[25];
  assign new_rec.signal     = in_tdata[33:26];
  assign read_index         = in_tdata[38:34];

  assign is_weak   = new_rec.signal <= min_signal_r;
  assign is_full   = 32'(count_r) >= 32'(MAX_RECORDS);
  assign ins_ok    = accept && (req == REQ_INSERT) && !is_weak && !is_full;
  assign not_found = (32'(read_index) >= 32'(count_r)) ||
                     (32'(read_index) >= 32'(MAX_RECORDS));

  // cell chain
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    assign ctl[i].ins    = ins_ok;
    assign ctl[i].valid  = CNT_W'(i) < count_r;
    assign ctl[i].at_end = count_r == CNT_W'(i);
    assign rd_sel[i]     = {27'd0, read_index} == 32'(i);

    if (i == 0) begin : g_head
      ssl_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .prev_gt  (1'b0),
        .prev_rec (new_rec),
        .new_rec  (new_rec),
        .gt       (gt[i]),
        .rec      (rec[i])
      );
    end else begin : g_body
      ssl_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[i]),
        .prev_gt  (gt[i-1]),
        .prev_rec (rec[i-1]),
        .new_rec  (new_rec),
        .gt       (gt[i]),
        .rec      (rec[i])
      );
    end
  end

  // read select: OR of the one addressed cell
  always_comb begin
    rd_bits = '0;
    for (int i = 0; i < MAX_RECORDS; i++) begin
      rd_bits = rd_bits | (rec[i] & {REC_W{rd_sel[i]}});
    end
  end
  assign rd_rec = rec_t'(rd_bits);

  // next count, result status and payload
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_user_nxt  = out_user_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = ST_OK;
      unique case (req)
        REQ_CLEAR:  count_nxt = '0;
        REQ_INSERT: begin
          if (is_weak) begin
            out_user_nxt = ST_WEAK;
          end else if (is_full) begin
            out_user_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_READ: begin
          if (not_found) begin
            out_user_nxt = ST_NOTFOUND;
          end
        end
        default: ;
      endcase
    end
  end

  // count after the request, masked to six bits
  assign count_ext = {6'd0, count_nxt};

  always_comb begin
    out_data_nxt = out_data_r;
    if (accept) begin
      out_data_nxt = {34'd0, count_ext[5:0]};
      if ((req == REQ_READ) && !not_found) begin
        out_data_nxt[39:32] = rd_rec.signal;
        out_data_nxt[31]    = rd_rec.in_use;
        out_data_nxt[30:23] = rd_rec.elevation;
        out_data_nxt[22:14] = rd_rec.azimuth;
        out_data_nxt[13:6]  = rd_rec.sat_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      min_signal_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_signal_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_RECORDS))
    else $error("count exceeds capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (req == REQ_CLEAR)) |=> (count_r == '0) && (out_tuser == ST_OK))
    else $error("clear did not empty the list");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (count_r == $past(count_r) + CNT_W'(1)) && (out_tuser == ST_OK))
    else $error("accepted insert did not add one record");

  for (genvar i = 1; i < MAX_RECORDS; i++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      ctl[i].valid |-> (rec[i-1].signal <= rec[i].signal))
      else $error("cell chain out of order");
  end

endmodule
